// ===== design/assert_macros.svh =====
// Assertion helpers; build with NO_ASSERTIONS defined to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/kkg_pkg.sv =====
`timescale 1ns / 1ps
package kkg_pkg;

   localparam int MAX_ORDER   = 31;
   localparam int STORE_DEPTH = MAX_ORDER + 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ORDER_W     = 5;
   localparam int COEF_W      = 32;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_CLEAR, S_ROWTEST, S_P0, S_P1, S_WALK, S_DTEST,
      S_E0, S_E1, S_ERR
   } step_type;

   typedef enum logic [1:0] {WAIT_NONE, WAIT_REQ, WAIT_SLOT} wait_type;

   typedef enum logic [2:0] {
      C_NEVER, C_BAD, C_IDX_END, C_ROW_END, C_PASS_END, C_RA_LIM
   } cond_type;

   typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_ONE, IDX_INC} idx_op_type;
   typedef enum logic [1:0] {RD_NONE, RD_ZERO, RD_IDX} rd_type;
   typedef enum logic [1:0] {WR_NONE, WR_INIT, WR_ALU} wr_type;
   typedef enum logic [1:0] {OUT_NONE, OUT_TAP, OUT_ERR} out_type;
   typedef enum logic {MODE_ADD, MODE_SUB} mode_type;

   typedef struct packed {
      wait_type   wait_on;
      cond_type   cond;
      logic       br_ret;
      step_type   br_step;
      step_type   next_step;
      idx_op_type idx_op;
      rd_type     rd_sel;
      wr_type     wr_sel;
      out_type    out_sel;
      logic       latch_req;
      logic       clr_counts;
      logic       row_setup;
      logic       pass_setup;
      logic       load_prev;
      logic       load_ra;
      logic       call;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic slot_free;
      logic bad;
      logic idx_end;
      logic row_end;
      logic pass_end;
      logic ra_lim;
   } status_type;

   // Microprogram. Pascal rows and differencing passes share the P0/P1/WALK
   // subroutine; ROWTEST and DTEST call it and WALK returns to the caller.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      case (step)
         S_IDLE: begin
            w.wait_on   = WAIT_REQ;
            w.latch_req = 1'b1;
            w.next_step = S_CHECK;
         end
         S_CHECK: begin
            w.cond       = C_BAD;
            w.br_step    = S_ERR;
            w.next_step  = S_CLEAR;
            w.idx_op     = IDX_ZERO;
            w.clr_counts = 1'b1;
         end
         S_CLEAR: begin
            w.wr_sel    = WR_INIT;
            w.idx_op    = IDX_INC;
            w.cond      = C_IDX_END;
            w.br_step   = S_ROWTEST;
            w.next_step = S_CLEAR;
         end
         S_ROWTEST: begin
            w.cond      = C_ROW_END;
            w.br_step   = S_DTEST;
            w.next_step = S_P0;
            w.row_setup = 1'b1;
            w.call      = 1'b1;
         end
         S_P0: begin
            w.rd_sel    = RD_ZERO;
            w.idx_op    = IDX_ONE;
            w.next_step = S_P1;
         end
         S_P1: begin
            w.load_prev = 1'b1;
            w.rd_sel    = RD_IDX;
            w.load_ra   = 1'b1;
            w.idx_op    = IDX_INC;
            w.next_step = S_WALK;
         end
         S_WALK: begin
            w.wr_sel    = WR_ALU;
            w.load_prev = 1'b1;
            w.rd_sel    = RD_IDX;
            w.load_ra   = 1'b1;
            w.idx_op    = IDX_INC;
            w.cond      = C_RA_LIM;
            w.br_ret    = 1'b1;
            w.next_step = S_WALK;
         end
         S_DTEST: begin
            w.cond       = C_PASS_END;
            w.br_step    = S_E0;
            w.next_step  = S_P0;
            w.pass_setup = 1'b1;
            w.call       = 1'b1;
            w.idx_op     = IDX_ZERO;
         end
         S_E0: begin
            w.rd_sel    = RD_IDX;
            w.next_step = S_E1;
         end
         S_E1: begin
            w.wait_on   = WAIT_SLOT;
            w.out_sel   = OUT_TAP;
            w.idx_op    = IDX_INC;
            w.cond      = C_IDX_END;
            w.br_step   = S_IDLE;
            w.next_step = S_E0;
         end
         S_ERR: begin
            w.wait_on   = WAIT_SLOT;
            w.out_sel   = OUT_ERR;
            w.next_step = S_IDLE;
         end
         default: begin
            w.next_step = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/kkg_ram.sv =====
`timescale 1ns / 1ps
module kkg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== design/kkg_sequencer.sv =====
`timescale 1ns / 1ps
module kkg_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  kkg_pkg::status_type status,
   output kkg_pkg::ucode_type  ctl,
   output logic               go
);
   import kkg_pkg::*;

   step_type step_ff, step_in;
   step_type ret_ff, ret_in;
   logic     cond_true;

   // control word for the current step
   always_comb begin
      ctl = ucode_rom(step_ff);
   end

   always_comb begin
      case (ctl.wait_on)
         WAIT_REQ:  go = status.req_valid;
         WAIT_SLOT: go = status.slot_free;
         default:   go = 1'b1;
      endcase
      case (ctl.cond)
         C_BAD:      cond_true = status.bad;
         C_IDX_END:  cond_true = status.idx_end;
         C_ROW_END:  cond_true = status.row_end;
         C_PASS_END: cond_true = status.pass_end;
         C_RA_LIM:   cond_true = status.ra_lim;
         default:    cond_true = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      ret_in  = ret_ff;
      if (go) begin
         if (cond_true) begin
            step_in = ctl.br_ret ? ret_ff : ctl.br_step;
         end else begin
            step_in = ctl.next_step;
         end
         if (ctl.call) begin
            ret_in = step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
         ret_ff  <= S_IDLE;
      end else begin
         step_ff <= step_in;
         ret_ff  <= ret_in;
      end
   end

endmodule

// ===== design/kkg_datapath.sv =====
`timescale 1ns / 1ps
module kkg_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  kkg_pkg::ucode_type                 ctl,
   input  logic                               go,
   output kkg_pkg::status_type                status,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [kkg_pkg::ORDER_W-1:0]        req_order,
   input  logic [kkg_pkg::ORDER_W-1:0]        req_degree,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [kkg_pkg::COEF_W-1:0]  rsp_coefficient,
   output logic [kkg_pkg::ORDER_W-1:0]        rsp_tap_index,
   output logic                               rsp_last,
   output logic                               rsp_error
);
   import kkg_pkg::*;

   logic [ORDER_W-1:0] order_ff, order_in;
   logic [ORDER_W-1:0] degree_ff, degree_in;
   logic [ORDER_W-1:0] cnt_ff, cnt_in;
   logic [ORDER_W-1:0] pass_ff, pass_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  ra_ff, ra_in;
   logic [ADDR_W-1:0]  lim_ff, lim_in;
   mode_type           mode_ff, mode_in;
   logic [COEF_W-1:0]  prev_ff, prev_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COEF_W-1:0]  rsp_coef_ff, rsp_coef_in;
   logic [ORDER_W-1:0] rsp_tap_ff, rsp_tap_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_error_ff, rsp_error_in;

   logic [ORDER_W-1:0] m_diff;
   logic [COEF_W-1:0]  alu;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [COEF_W-1:0]  wr_data, rd_data;

   kkg_ram #(
      .WIDTH (COEF_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign m_diff = order_ff - degree_ff;
   assign alu    = (mode_ff == MODE_ADD) ? rd_data + prev_ff : rd_data - prev_ff;

   always_comb begin
      status.req_valid = req_valid;
      status.slot_free = !rsp_valid_ff || !rsp_stall;
      status.bad       = (degree_ff > order_ff) || (int'(order_ff) > MAX_ORDER);
      status.idx_end   = (idx_ff == ADDR_W'(order_ff));
      status.row_end   = (cnt_ff == m_diff);
      status.pass_end  = (pass_ff == degree_ff);
      status.ra_lim    = (ra_ff == lim_ff);
   end

   assign req_stall = (ctl.wait_on != WAIT_REQ);

   // store port: clear writes at idx, passes write back at the address read last cycle
   always_comb begin
      wr_en   = go && (ctl.wr_sel != WR_NONE);
      rd_en   = go && (ctl.rd_sel != RD_NONE);
      wr_addr = (ctl.wr_sel == WR_ALU) ? ra_ff : idx_ff;
      if (ctl.wr_sel == WR_ALU) begin
         wr_data = alu;
      end else begin
         wr_data = (idx_ff == '0) ? COEF_W'(1) : '0;
      end
      rd_addr = (ctl.rd_sel == RD_ZERO) ? '0 : idx_ff;
   end

   always_comb begin
      order_in     = order_ff;
      degree_in    = degree_ff;
      cnt_in       = cnt_ff;
      pass_in      = pass_ff;
      idx_in       = idx_ff;
      ra_in        = ra_ff;
      lim_in       = lim_ff;
      mode_in      = mode_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_coef_in  = rsp_coef_ff;
      rsp_tap_in   = rsp_tap_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_error_in = rsp_error_ff;
      if (go) begin
         if (ctl.latch_req) begin
            order_in  = req_order;
            degree_in = req_degree;
         end
         if (ctl.clr_counts) begin
            cnt_in  = '0;
            pass_in = '0;
         end
         if (ctl.row_setup) begin
            cnt_in  = cnt_ff + 1'b1;
            lim_in  = ADDR_W'(cnt_ff + 1'b1);
            mode_in = MODE_ADD;
         end
         if (ctl.pass_setup) begin
            pass_in = pass_ff + 1'b1;
            lim_in  = ADDR_W'(order_ff);
            mode_in = MODE_SUB;
         end
         case (ctl.idx_op)
            IDX_ZERO: idx_in = '0;
            IDX_ONE:  idx_in = ADDR_W'(1);
            IDX_INC:  idx_in = idx_ff + 1'b1;
            default:  idx_in = idx_ff;
         endcase
         if (ctl.load_prev) begin
            prev_in = rd_data;
         end
         if (ctl.load_ra) begin
            ra_in = idx_ff;
         end
         case (ctl.out_sel)
            OUT_TAP: begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = rd_data;
               rsp_tap_in   = ORDER_W'(idx_ff);
               rsp_last_in  = status.idx_end;
               rsp_error_in = 1'b0;
            end
            OUT_ERR: begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = '0;
               rsp_tap_in   = '0;
               rsp_last_in  = 1'b1;
               rsp_error_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      order_ff     <= order_in;
      degree_ff    <= degree_in;
      cnt_ff       <= cnt_in;
      pass_ff      <= pass_in;
      idx_ff       <= idx_in;
      ra_ff        <= ra_in;
      lim_ff       <= lim_in;
      mode_ff      <= mode_in;
      prev_ff      <= prev_in;
      rsp_coef_ff  <= rsp_coef_in;
      rsp_tap_ff   <= rsp_tap_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = signed'(rsp_coef_ff);
   assign rsp_tap_index   = rsp_tap_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_error       = rsp_error_ff;

endmodule

// ===== design/krawtchouk_kernel_generator.sv =====
`timescale 1ns / 1ps
// Krawtchouk binomial-difference kernel generator.
// Request channel (req_*): order and degree; a transfer happens when req_valid
// is high and req_stall low. req_stall is low only while the block is idle.
// Response channel (rsp_*): order+1 coefficients, tap 0 first, rsp_last on the
// final one. degree > order gives a single transfer with rsp_error set.
// Work runs as a microprogram over one 32-word store with one adder: accept,
// check, clear entries 0..order, build Pascal rows r=1..m with m = order-degree,
// run degree differencing passes, then emit the taps one by one.
// One request is processed at a time.
// A stalled response holds its register and the sequencer waits on it;
// nothing is dropped. Synchronous active-high reset returns the sequencer to
// idle and empties the response register; the store needs no clearing since
// every request rewrites the entries it reads.
`include "assert_macros.svh"
module krawtchouk_kernel_generator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [kkg_pkg::ORDER_W-1:0]        req_order,
   input  logic [kkg_pkg::ORDER_W-1:0]        req_degree,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [kkg_pkg::COEF_W-1:0]  rsp_coefficient,
   output logic [kkg_pkg::ORDER_W-1:0]        rsp_tap_index,
   output logic                               rsp_last,
   output logic                               rsp_error
);
   import kkg_pkg::*;

   ucode_type  ctl;
   status_type status;
   logic       go;
   logic       err_shape_ok;

   kkg_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl),
      .go     (go)
   );

   kkg_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .go              (go),
      .status          (status),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_order       (req_order),
      .req_degree      (req_degree),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_coefficient (rsp_coefficient),
      .rsp_tap_index   (rsp_tap_index),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error)
   );

   assign err_shape_ok = rsp_last && (rsp_coefficient == '0) && (rsp_tap_index == '0);

   // error result carries no kernel
   `ASSERT_IMPLY(a_err_shape, clock, reset, rsp_valid && rsp_error, err_shape_ok)
   // the block leaves idle right after a request transfer
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   // mid-kernel results only appear while the request is still being worked
   `ASSERT_IMPLY(a_mid_kernel_busy, clock, reset, rsp_valid && !rsp_last, req_stall)

endmodule
